@@ hw/rtl/boundary_region_labeling_top_defines.svh @@
// assertion macros for the boundary region labeler
// clk and rst_n are taken from the scope of the use
`ifndef BOUNDARY_REGION_LABELING_TOP_DEFINES_SVH
`define BOUNDARY_REGION_LABELING_TOP_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define BRL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("boundary labeler check failed");

// next-cycle implication
`define BRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("boundary labeler check failed");

`else

`define BRL_ASSERT_NOW(lbl, ante, cons)
`define BRL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/brl_pkg.sv @@
package brl_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int LABEL_W    = 12;
  localparam int INDEX_W    = 12;

  localparam logic [CFG_IDX_W-1:0]  CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_IMAGE_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 7'd64;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 7'd64;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_LABEL = 1'b1;

  localparam logic [LABEL_W-1:0] LABEL_TOP = 12'd4095;

  // luma weights and compositing constants
  localparam logic [13:0] LUMA_R     = 14'd4899;
  localparam logic [13:0] LUMA_G     = 14'd9617;
  localparam logic [13:0] LUMA_B     = 14'd1868;
  localparam logic [13:0] LUMA_BIAS  = 14'd8192;
  localparam int          LUMA_SHIFT = 14;
  localparam logic [7:0]  ALPHA_MAX  = 8'd255;
  localparam logic [6:0]  ROUND_BIAS = 7'd127;
  localparam int          BND_THRESH = 128;
  // floor(x / 255) <= 128 holds exactly when x < 129 * 255
  localparam logic [16:0] BND_LIMIT  = 17'((BND_THRESH + 1) * 255);

  typedef struct packed {
    logic                 cmd;
    logic [31:0]          pixel_rgba;
    logic                 last_pixel;
    logic [INDEX_W-1:0]   read_index;
  } in_item_t;

  typedef struct packed {
    logic                 result_kind;
    logic [LABEL_W-1:0]   result_value;
  } out_item_t;

  typedef enum logic [1:0] {
    NB_LEFT,
    NB_RIGHT,
    NB_UP,
    NB_DOWN
  } nb_dir_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_LD_MUL,
    ST_LD_LUMA,
    ST_LD_WR,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_LB_CLR,
    ST_SEED_RD,
    ST_SEED_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_NB_RD,
    ST_NB_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_all;
    logic ld_mul;
    logic ld_luma;
    logic ld_wr;
    logic rd_addr;
    logic rd_out;
    logic lb_clr;
    logic seed_rd;
    logic seed_chk;
    logic pop;
    logic pop_pos;
    logic nb_rd;
    logic nb_chk;
    logic done_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic last;
    logic clr_all_last;
    logic lb_clr_last;
    logic pix_free;
    logic seed_last;
    logic q_empty;
    logic nb_last;
  } dp_stat_t;

endpackage

@@ hw/rtl/brl_ram.sv @@
module brl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/brl_ctrl.sv @@
module brl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_cmd,
  input  brl_pkg::dp_stat_t stat,
  output logic              busy,
  output brl_pkg::ctl_cmd_t cmd
);
  import brl_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:      if (stat.clr_all_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) state_nxt = (in_cmd == CMD_READ) ? ST_RD_ADDR : ST_LD_MUL;
      end
      ST_LD_MUL:   state_nxt = ST_LD_LUMA;
      ST_LD_LUMA:  state_nxt = ST_LD_WR;
      ST_LD_WR:    state_nxt = stat.last ? ST_LB_CLR : ST_IDLE;
      ST_RD_ADDR:  state_nxt = ST_RD_DATA;
      ST_RD_DATA:  state_nxt = ST_IDLE;
      ST_LB_CLR:   if (stat.lb_clr_last) state_nxt = ST_SEED_RD;
      ST_SEED_RD:  state_nxt = ST_SEED_CHK;
      ST_SEED_CHK: begin
        priority if (stat.pix_free) state_nxt = ST_POP;
        else if (stat.seed_last)    state_nxt = ST_DONE;
        else                        state_nxt = ST_SEED_RD;
      end
      ST_POP: begin
        priority if (!stat.q_empty) state_nxt = ST_POP_WAIT;
        else if (stat.seed_last)    state_nxt = ST_DONE;
        else                        state_nxt = ST_SEED_RD;
      end
      ST_POP_WAIT: state_nxt = ST_NB_RD;
      ST_NB_RD:    state_nxt = ST_NB_CHK;
      ST_NB_CHK:   state_nxt = stat.nb_last ? ST_POP : ST_NB_RD;
      ST_DONE:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_CLR:      cmd.clr_all  = 1'b1;
      ST_IDLE:     cmd.accept   = start;
      ST_LD_MUL:   cmd.ld_mul   = 1'b1;
      ST_LD_LUMA:  cmd.ld_luma  = 1'b1;
      ST_LD_WR:    cmd.ld_wr    = 1'b1;
      ST_RD_ADDR:  cmd.rd_addr  = 1'b1;
      ST_RD_DATA:  cmd.rd_out   = 1'b1;
      ST_LB_CLR:   cmd.lb_clr   = 1'b1;
      ST_SEED_RD:  cmd.seed_rd  = 1'b1;
      ST_SEED_CHK: cmd.seed_chk = 1'b1;
      ST_POP:      cmd.pop      = 1'b1;
      ST_POP_WAIT: cmd.pop_pos  = 1'b1;
      ST_NB_RD:    cmd.nb_rd    = 1'b1;
      ST_NB_CHK:   cmd.nb_chk   = 1'b1;
      ST_DONE:     cmd.done_out = 1'b1;
    endcase
  end

endmodule

@@ hw/rtl/brl_datapath.sv @@
module brl_datapath #(
  parameter int MAX_WIDTH  = brl_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = brl_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [brl_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [brl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  brl_pkg::in_item_t                in_item,
  input  brl_pkg::ctl_cmd_t                cmd,
  output brl_pkg::dp_stat_t                stat,
  output logic                             out_valid,
  output brl_pkg::out_item_t               out_item
);
  import brl_pkg::*;

  localparam int PIX_CAP = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (PIX_CAP > 1) ? $clog2(PIX_CAP) : 1;
  localparam int CW = $clog2(PIX_CAP + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int QW = XW + YW;

  // configuration
  logic [CFG_DATA_W-1:0] img_w_r, img_h_r;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic [CW-1:0]         n_r;

  // latched command
  logic [31:0]           rgba_r;
  logic                  last_r;
  logic [INDEX_W-1:0]    ridx_r;

  // luma / composite pipeline
  logic [21:0]           pr_r, pg_r, pb_r;
  logic [7:0]            a_r;
  logic [15:0]           la_r, wa_r;
  logic [7:0]            luma;
  logic [16:0]           comp_sum;
  logic                  bnd;
  logic                  ld_room;

  // control counters
  logic [CW-1:0]         ldptr_r;
  logic [CW-1:0]         clr_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  // flood fill state
  logic [LABEL_W-1:0]    nl_r, nl_new;
  logic [AW-1:0]         s_r;
  logic [XW-1:0]         sx_r, x_r, nb_x, nbx_r;
  logic [YW-1:0]         sy_r, y_r, nb_y, nby_r;
  logic [AW-1:0]         p_r, nb_addr, nba_r;
  logic                  nb_ok, nb_ok_r;
  nb_dir_t               k_r;
  logic [CW-1:0]         head_r, tail_r;

  // memory ports
  logic                  lbl_we, bm_we, q_we, pix_re, q_re;
  logic [AW-1:0]         lbl_wa, bm_wa, q_wa, pix_ra, q_ra;
  logic [LABEL_W-1:0]    lbl_wd, lbl_q;
  logic                  bm_wd, bm_q;
  logic [QW-1:0]         q_wd, q_q;
  logic                  pix_free, in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_wdata;
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_wdata;
      endcase
    end
  end

  // zero counts as one, clamp at the maximum
  always_comb begin
    if (img_w_r == '0) w_eff = WW'(1);
    else if (32'(img_w_r) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(img_w_r);
    if (img_h_r == '0) h_eff = HW'(1);
    else if (32'(img_h_r) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(img_h_r);
  end

  assign luma     = 8'((24'(pr_r) + 24'(pg_r) + 24'(pb_r) + 24'(LUMA_BIAS)) >> LUMA_SHIFT);
  assign comp_sum = 17'(la_r) + 17'(wa_r) + 17'(ROUND_BIAS);
  assign bnd      = (comp_sum < BND_LIMIT);
  assign ld_room  = (32'(ldptr_r) < 32'(n_r));
  assign in_range = (32'(ridx_r) < 32'(n_r));
  assign pix_free = (lbl_q == '0) && (bm_q == 1'b0);
  assign nl_new   = (nl_r == LABEL_TOP) ? nl_r : nl_r + LABEL_W'(1);

  // neighbor of the popped pixel
  always_comb begin
    nb_x    = x_r;
    nb_y    = y_r;
    nb_ok   = 1'b0;
    nb_addr = p_r;
    unique case (k_r)
      NB_LEFT: begin
        nb_ok   = (x_r != '0);
        nb_x    = x_r - XW'(1);
        nb_addr = p_r - AW'(1);
      end
      NB_RIGHT: begin
        nb_ok   = (32'(x_r) + 32'd1 < 32'(w_eff));
        nb_x    = x_r + XW'(1);
        nb_addr = p_r + AW'(1);
      end
      NB_UP: begin
        nb_ok   = (y_r != '0);
        nb_y    = y_r - YW'(1);
        nb_addr = p_r - AW'(w_eff);
      end
      NB_DOWN: begin
        nb_ok   = (32'(y_r) + 32'd1 < 32'(h_eff));
        nb_y    = y_r + YW'(1);
        nb_addr = p_r + AW'(w_eff);
      end
    endcase
  end

  // memory port steering
  always_comb begin
    lbl_we = 1'b0;
    lbl_wa = clr_r[AW-1:0];
    lbl_wd = '0;
    bm_we  = 1'b0;
    bm_wa  = clr_r[AW-1:0];
    bm_wd  = 1'b1;
    q_we   = 1'b0;
    q_wa   = tail_r[AW-1:0];
    q_wd   = {sy_r, sx_r};
    pix_re = 1'b0;
    pix_ra = s_r;
    q_re   = 1'b0;
    q_ra   = head_r[AW-1:0];
    if (cmd.clr_all) begin
      lbl_we = 1'b1;
      bm_we  = 1'b1;
    end
    if (cmd.lb_clr) lbl_we = 1'b1;
    if (cmd.ld_wr && ld_room) begin
      bm_we = 1'b1;
      bm_wa = ldptr_r[AW-1:0];
      bm_wd = bnd;
    end
    if (cmd.rd_addr) begin
      pix_re = 1'b1;
      pix_ra = AW'(ridx_r);
    end
    if (cmd.seed_rd) pix_re = 1'b1;
    if (cmd.seed_chk && pix_free) begin
      lbl_we = 1'b1;
      lbl_wa = s_r;
      lbl_wd = nl_new;
      q_we   = 1'b1;
      q_wa   = '0;
    end
    if (cmd.pop && (head_r != tail_r)) q_re = 1'b1;
    if (cmd.nb_rd) begin
      pix_re = 1'b1;
      pix_ra = nb_addr;
    end
    if (cmd.nb_chk && nb_ok_r && pix_free) begin
      lbl_we = 1'b1;
      lbl_wa = nba_r;
      lbl_wd = nl_r;
      q_we   = 1'b1;
      q_wd   = {nby_r, nbx_r};
    end
  end

  brl_ram #(.WIDTH(LABEL_W), .DEPTH(PIX_CAP), .AW(AW)) u_label_ram (
    .clk(clk), .we(lbl_we), .waddr(lbl_wa), .wdata(lbl_wd),
    .re(pix_re), .raddr(pix_ra), .rdata(lbl_q)
  );

  brl_ram #(.WIDTH(1), .DEPTH(PIX_CAP), .AW(AW)) u_bmap_ram (
    .clk(clk), .we(bm_we), .waddr(bm_wa), .wdata(bm_wd),
    .re(pix_re), .raddr(pix_ra), .rdata(bm_q)
  );

  brl_ram #(.WIDTH(QW), .DEPTH(PIX_CAP), .AW(AW)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .re(q_re), .raddr(q_ra), .rdata(q_q)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldptr_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      nl_r        <= '0;
    end else begin
      out_valid_r <= cmd.done_out || cmd.rd_out;
      if (cmd.clr_all || cmd.lb_clr) clr_r <= clr_r + CW'(1);
      if (cmd.ld_wr) begin
        clr_r <= '0;
        if (ld_room) ldptr_r <= ldptr_r + CW'(1);
        if (last_r) nl_r <= '0;
      end
      if (cmd.seed_chk && pix_free) nl_r <= nl_new;
      if (cmd.done_out) ldptr_r <= '0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r <= CW'(32'(w_eff) * 32'(h_eff));
    if (cmd.accept) begin
      rgba_r <= in_item.pixel_rgba;
      last_r <= in_item.last_pixel;
      ridx_r <= in_item.read_index;
    end
    if (cmd.ld_mul) begin
      pr_r <= 22'(rgba_r[7:0])   * 22'(LUMA_R);
      pg_r <= 22'(rgba_r[15:8])  * 22'(LUMA_G);
      pb_r <= 22'(rgba_r[23:16]) * 22'(LUMA_B);
      a_r  <= rgba_r[31:24];
    end
    if (cmd.ld_luma) begin
      la_r <= 16'(luma) * 16'(a_r);
      wa_r <= 16'(ALPHA_MAX - a_r) * 16'(ALPHA_MAX);
    end
    if (cmd.ld_wr && last_r) begin
      s_r  <= '0;
      sx_r <= '0;
      sy_r <= '0;
    end
    if (cmd.seed_chk && pix_free) begin
      head_r <= '0;
      tail_r <= CW'(1);
    end
    // seed advance: on a taken or boundary seed, or when its region is done
    if ((cmd.seed_chk && !pix_free) || (cmd.pop && (head_r == tail_r))) begin
      s_r <= s_r + AW'(1);
      if (32'(sx_r) + 32'd1 == 32'(w_eff)) begin
        sx_r <= '0;
        sy_r <= sy_r + YW'(1);
      end else begin
        sx_r <= sx_r + XW'(1);
      end
    end
    if (cmd.pop && (head_r != tail_r)) head_r <= head_r + CW'(1);
    if (cmd.pop_pos) begin
      x_r <= q_q[XW-1:0];
      y_r <= q_q[QW-1:XW];
      p_r <= AW'(32'(q_q[QW-1:XW]) * 32'(w_eff) + 32'(q_q[XW-1:0]));
      k_r <= NB_LEFT;
    end
    if (cmd.nb_rd) begin
      nb_ok_r <= nb_ok;
      nbx_r   <= nb_x;
      nby_r   <= nb_y;
      nba_r   <= nb_addr;
    end
    if (cmd.nb_chk) begin
      k_r <= nb_dir_t'(k_r + 2'd1);
      if (nb_ok_r && pix_free) tail_r <= tail_r + CW'(1);
    end
    if (cmd.done_out) begin
      out_item_r.result_kind  <= KIND_DONE;
      out_item_r.result_value <= nl_r;
    end
    if (cmd.rd_out) begin
      out_item_r.result_kind  <= KIND_LABEL;
      out_item_r.result_value <= in_range ? lbl_q : '0;
    end
  end

  always_comb begin
    stat.last         = last_r;
    stat.clr_all_last = (32'(clr_r) == 32'(PIX_CAP - 1));
    // every label is cleared, not only those of the current image
    stat.lb_clr_last  = (32'(clr_r) == 32'(PIX_CAP - 1));
    stat.pix_free     = pix_free;
    stat.seed_last    = (32'(s_r) + 32'd1 == 32'(n_r));
    stat.q_empty      = (head_r == tail_r);
    stat.nb_last      = (k_r == NB_DOWN);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ hw/rtl/boundary_region_labeling_top.sv @@
// channel | ports                                  | handshake
// input   | start, busy, in_item                   | taken when start high, busy low
// result  | out_valid, out_item                    | one-cycle strobe, no back pressure
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | taken when valid and ready high
//
// steps: a pixel load goes through accept, two multiply stages and the map write;
//   a label read goes through accept, ram read and the result register
// labeling after the last pixel: every label is cleared, then seeds are scanned;
//   each filled pixel is popped and its neighbors checked (one ram read port)
// reset: a pass over every pixel marks it boundary, zeroes its label, busy high
// config writes are taken in any cycle; the receiver cannot stall results
module boundary_region_labeling_top #(
  parameter int MAX_WIDTH  = brl_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = brl_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  brl_pkg::in_item_t              in_item,
  output logic                           out_valid,
  output brl_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [brl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import brl_pkg::*;

`include "boundary_region_labeling_top_defines.svh"

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;
  logic     cfg_we;

  // registers are always writable
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: load, read and flood fill phases
  brl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_item.cmd),
    .stat   (dp_stat),
    .busy   (busy),
    .cmd    (ctl_cmd)
  );

  // pixel maps, bfs queue and result register
  brl_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_item   (in_item),
    .cmd       (ctl_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // a result only shows once the block is free again
  `BRL_ASSERT_NOW(a_result_when_idle, out_valid, !busy)
  // results are single-cycle strobes
  `BRL_ASSERT_NEXT(a_result_one_cycle, out_valid, !out_valid)
  // an accepted item keeps the block busy next cycle
  `BRL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import brl_pkg::*;

  localparam int PIX_CAP      = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int SETTLE_CYC   = 40;
  localparam int WATCHDOG_CYC = 250000;
  localparam int ITEM_BUDGET  = 1100;
  localparam int IN_W         = $bits(in_item_t);

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  boundary_region_labeling_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // pending items for the driver, expected results for the monitor
  in_item_t pixel_cmd_q[$];
  out_item_t label_exp_q[$];
  int errors;
  int items_queued;

  // shadow copy of the labeler state
  bit dark_map[PIX_CAP];
  logic [LABEL_W-1:0] label_mem[PIX_CAP];
  int fill_fifo[PIX_CAP];
  int load_ptr;
  int region_cnt;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;

  // driver state
  in_item_t cur_item;
  bit holding;
  bit item_taken;
  bit no_idle;
  int gap_cnt;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamp a size register the way the block does
  function automatic int clamp_dim(logic [CFG_DATA_W-1:0] v, int top);
    if (v == 0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // luma, composite over white, threshold at 128
  function automatic bit pixel_is_dark(logic [31:0] rgba);
    int unsigned r, g, b, a, luma, comp;
    r = rgba[7:0];
    g = rgba[15:8];
    b = rgba[23:16];
    a = rgba[31:24];
    luma = (r * 4899 + g * 9617 + b * 1868 + 8192) >> 14;
    comp = (luma * a + 255 * (255 - a) + 127) / 255;
    return comp <= 128;
  endfunction

  function automatic void claim_pixel(int pos, ref int tail);
    if (pos >= PIX_CAP || tail >= PIX_CAP) return;
    if (label_mem[pos] != 0 || dark_map[pos]) return;
    label_mem[pos] = LABEL_W'(region_cnt);
    fill_fifo[tail] = pos;
    tail++;
  endfunction

  // breadth-first flood fill with seeds in raster order
  function automatic void flood_fill_regions();
    int w, h, n, head, tail, p, x, y;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    n = w * h;
    foreach (label_mem[i]) label_mem[i] = '0;
    region_cnt = 0;
    for (int s = 0; s < n; s++) begin
      if (label_mem[s] != 0 || dark_map[s]) continue;
      if (region_cnt < int'(LABEL_TOP)) region_cnt++;
      label_mem[s] = LABEL_W'(region_cnt);
      head = 0;
      tail = 1;
      fill_fifo[0] = s;
      while (head < tail) begin
        p = fill_fifo[head];
        head++;
        x = p % w;
        y = p / w;
        if (x > 0) claim_pixel(p - 1, tail);
        if (x + 1 < w) claim_pixel(p + 1, tail);
        if (y > 0) claim_pixel(p - w, tail);
        if (y + 1 < h) claim_pixel(p + w, tail);
      end
    end
    load_ptr = 0;
  endfunction

  // work out what one accepted item produces
  function automatic void predict_labels(in_item_t it);
    out_item_t r;
    int n;
    n = clamp_dim(width_reg, DEF_MAX_WIDTH) * clamp_dim(height_reg, DEF_MAX_HEIGHT);
    if (it.cmd == CMD_READ) begin
      r.result_kind = KIND_LABEL;
      r.result_value = (int'(it.read_index) < n) ? label_mem[it.read_index] : '0;
      label_exp_q = {label_exp_q, r};
      return;
    end
    if (load_ptr < n) begin
      dark_map[load_ptr] = pixel_is_dark(it.pixel_rgba);
      load_ptr++;
    end
    if (!it.last_pixel) return;
    flood_fill_regions();
    r.result_kind = KIND_DONE;
    r.result_value = LABEL_W'(region_cnt);
    label_exp_q = {label_exp_q, r};
  endfunction

  // monitor: results, accepted items, config writes, watchdog
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      idle_cycles++;
      if (out_valid) begin
        idle_cycles = 0;
        if (label_exp_q.size() == 0) begin
          $error("unexpected result kind=%0d value=%0d",
                 out_item.result_kind, out_item.result_value);
          errors++;
        end else begin
          want = label_exp_q.pop_front();
          if (out_item.result_kind !== want.result_kind) begin
            $error("result_kind expected %0d actual %0d",
                   want.result_kind, out_item.result_kind);
            errors++;
          end
          if (out_item.result_value !== want.result_value) begin
            $error("result_value expected %0d actual %0d",
                   want.result_value, out_item.result_value);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        idle_cycles = 0;
        predict_labels(in_item);
        item_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        idle_cycles = 0;
        if (cfg_index == CFG_IMAGE_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (idle_cycles >= WATCHDOG_CYC) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // driver: one item at a time from the pending queue, random gaps
  always @(negedge clk) begin
    in_item_t noise;
    if (rst_n) begin
      if (item_taken) begin
        item_taken = 1'b0;
        holding = 1'b0;
        gap_cnt = no_idle ? 0 : $urandom_range(0, 16);
      end
      if (!holding) begin
        if (gap_cnt > 0) gap_cnt--;
        else if (pixel_cmd_q.size() > 0) begin
          cur_item = pixel_cmd_q.pop_front();
          holding = 1'b1;
        end
      end
      noise = IN_W'({$urandom, $urandom});
      start <= holding;
      in_item <= holding ? cur_item : noise;
    end
  end

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 4))
      0, 1: return {8'($urandom_range(200, 255)), 24'($urandom_range(0, 16'h7fff))};
      2, 3: return {8'($urandom_range(180, 255)), 8'($urandom_range(200, 255)),
                    8'($urandom_range(200, 255)), 8'($urandom_range(200, 255))};
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_load(logic [31:0] rgba, bit last);
    in_item_t it;
    it.cmd = CMD_LOAD;
    it.pixel_rgba = rgba;
    it.last_pixel = last;
    it.read_index = INDEX_W'($urandom);
    pixel_cmd_q = {pixel_cmd_q, it};
    items_queued++;
  endfunction

  function automatic void push_read(int idx);
    in_item_t it;
    it.cmd = CMD_READ;
    it.pixel_rgba = $urandom;
    it.last_pixel = 1'($urandom);
    it.read_index = INDEX_W'(idx);
    pixel_cmd_q = {pixel_cmd_q, it};
    items_queued++;
  endfunction

  // block is idle: nothing pending, nothing expected, no pixel in flight
  task automatic wait_idle();
    wait (pixel_cmd_q.size() == 0 && !holding && label_exp_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] w, h;
    int n, loads, reads, sel;
    errors = 0;
    items_queued = 0;
    holding = 1'b0;
    item_taken = 1'b0;
    no_idle = 1'b0;
    gap_cnt = 0;
    idle_cycles = 0;
    load_ptr = 0;
    region_cnt = 0;
    width_reg = RST_IMAGE_WIDTH;
    height_reg = RST_IMAGE_HEIGHT;
    foreach (dark_map[i]) dark_map[i] = 1'b1;
    foreach (label_mem[i]) label_mem[i] = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reads before any labeling come back as zero
    push_read(0);
    push_read(4095);
    // early last pixel at full size, rest of the map stays boundary
    push_load(32'h0000_0000, 1'b0);  // transparent reads as white
    push_load(32'hffff_ffff, 1'b0);
    push_load(32'hff00_0000, 1'b0);  // opaque black
    push_load(32'hff80_8080, 1'b1);
    push_read(0);
    push_read(1);
    push_read(3);
    push_read(4095);
    // zero sizes count as one pixel, extra loads are dropped
    set_size(7'd0, 7'd0);
    push_load(32'hffff_ffff, 1'b0);
    push_load(32'hff00_0000, 1'b0);
    push_load(32'hff00_0000, 1'b1);
    push_read(0);
    push_read(1);
    // oversized registers clamp to the maximum
    set_size(7'd127, 7'd1);
    for (int i = 0; i < 6; i++) push_load(i[0] ? 32'hff00_0000 : 32'hffff_ffff, i == 5);
    push_read(2);
    push_read(63);
    push_read(64);

    // random images, mostly small
    while (items_queued < ITEM_BUDGET) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        w = 7'($urandom_range(64, 127));
        h = 7'($urandom_range(64, 127));
      end else if (sel == 1) begin
        w = 7'd64;
        h = 7'($urandom_range(0, 2));
      end else if (sel == 2) begin
        w = 7'($urandom_range(0, 2));
        h = 7'd64;
      end else begin
        w = 7'($urandom_range(0, 8));
        h = 7'($urandom_range(0, 8));
      end
      set_size(w, h);
      no_idle = ($urandom_range(0, 3) == 0);
      n = clamp_dim(w, DEF_MAX_WIDTH) * clamp_dim(h, DEF_MAX_HEIGHT);
      if (n > 200) loads = $urandom_range(1, 60);
      else case ($urandom_range(0, 5))
        0: loads = $urandom_range(1, n);
        1: loads = n + $urandom_range(1, 3);
        default: loads = n;
      endcase
      for (int i = 0; i < loads; i++) push_load(rand_pixel(), i == loads - 1);
      reads = $urandom_range(2, 12);
      for (int i = 0; i < reads; i++)
        push_read($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                           : $urandom_range(0, n + 2));
    end

    wait_idle();
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/brl_pkg.sv
hw/rtl/brl_ram.sv
hw/rtl/brl_ctrl.sv
hw/rtl/brl_datapath.sv
hw/rtl/boundary_region_labeling_top.sv
dv/tb_top.sv
